// File: sv/matrix_vector_multiply_macros.svh
// assertion macros for the matrix vector multiply block
// used by the top level only; expects clk and rst_n in scope
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`ifndef ASSERT_OFF
`define MVM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MVM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MVM_ASSERT_IMPL(label, ante, cons)
`define MVM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/mvm_pkg.sv
// shared types and constants for the matrix vector multiply block
// no dependencies
package mvm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 32;
    localparam int DOT_W       = 48;
    localparam int ROW_INDEX_W = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    // wide enough for any count up to the largest supported size
    localparam int CNT_W       = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

    // item kinds on the action field
    localparam logic ACT_VECTOR = 1'b0;
    localparam logic ACT_WEIGHT = 1'b1;

    // row bookkeeping that travels with each weight item
    typedef struct packed {
        logic                   row_end;
        logic                   last_row;
        logic [ROW_INDEX_W-1:0] row_index;
    } row_tag_t;

endpackage

// File: sv/mvm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/matrix_vector_multiply.sv
// matrix vector multiply: row result registered after its last weight's product is summed
// throughput one item per cycle; input stalls only while a finished row waits on a stalled result
// pipeline: vector memory read, 16x16 multiply register, 48 bit accumulate into result register
// reset clears counters, accumulator, pipeline valids and sets both sizes to 1
// the vector memory is not cleared; entries read before being written are undefined
module matrix_vector_multiply #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // config port
    input  logic                                   cfg_write_en,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mvm_pkg::CFG_W-1:0]              cfg_data,
    // input items
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic                                   action,
    input  logic signed [mvm_pkg::SAMPLE_W-1:0]    sample_value,
    // result items
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [mvm_pkg::DOT_W-1:0]       dot_value,
    output logic [mvm_pkg::ROW_INDEX_W-1:0]        row_index,
    output logic                                   last_row
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = mvm_pkg::CNT_W;

    // config registers
    logic [mvm_pkg::CFG_W-1:0] rows_reg;
    logic [mvm_pkg::CFG_W-1:0] cols_reg;
    logic [mvm_pkg::CFG_W-1:0] cfg_rows_next;
    logic [mvm_pkg::CFG_W-1:0] cfg_cols_next;

    // sequencing state
    logic [COL_W-1:0] load_idx_reg;
    logic [COL_W-1:0] load_idx_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // pipeline
    logic                                   s1_valid_reg;
    logic signed [mvm_pkg::SAMPLE_W-1:0]    s1_sample_reg;
    mvm_pkg::row_tag_t                      s1_tag_reg;
    logic [mvm_pkg::SAMPLE_W-1:0]           vec_rdata;
    logic                                   s2_valid_reg;
    logic signed [mvm_pkg::PROD_W-1:0]      prod_reg;
    mvm_pkg::row_tag_t                      s2_tag_reg;
    logic signed [mvm_pkg::DOT_W-1:0]       acc_reg;
    logic signed [mvm_pkg::DOT_W-1:0]       acc_sum;
    logic                                   result_valid_reg;
    logic signed [mvm_pkg::DOT_W-1:0]       dot_reg;
    logic [mvm_pkg::ROW_INDEX_W-1:0]        row_index_reg;
    logic                                   last_row_reg;

    logic              hold;
    logic              accept;
    logic              vec_write;
    logic              weight_read;
    logic              row_end;
    logic              row_last;
    mvm_pkg::row_tag_t tag_next;

    // pipeline freezes only when a finished row meets a full, stalled result register
    assign hold         = s2_valid_reg && s2_tag_reg.row_end && result_valid_reg && result_stall;
    assign sample_stall = hold;
    assign accept       = sample_valid && !hold;
    assign vec_write    = accept && (action == mvm_pkg::ACT_VECTOR);
    assign weight_read  = accept && (action == mvm_pkg::ACT_WEIGHT);

    // clamp written sizes into 1..max
    always_comb
    begin
        if (cfg_data == '0)
            cfg_rows_next = mvm_pkg::CFG_W'(1);
        else if (CNT_W'(cfg_data) > CNT_W'(MAX_ROWS))
            cfg_rows_next = mvm_pkg::CFG_W'(MAX_ROWS);
        else
            cfg_rows_next = cfg_data;

        if (cfg_data == '0)
            cfg_cols_next = mvm_pkg::CFG_W'(1);
        else if (CNT_W'(cfg_data) > CNT_W'(MAX_COLS))
            cfg_cols_next = mvm_pkg::CFG_W'(MAX_COLS);
        else
            cfg_cols_next = cfg_data;
    end

    // counter next values
    always_comb
    begin
        if (CNT_W'(load_idx_reg) + CNT_W'(1) >= CNT_W'(cols_reg))
            load_idx_next = '0;
        else
            load_idx_next = load_idx_reg + COL_W'(1);

        row_end  = (CNT_W'(col_reg) + CNT_W'(1) >= CNT_W'(cols_reg));
        row_last = (CNT_W'(row_reg) + CNT_W'(1) >= CNT_W'(rows_reg));
        col_next = row_end ? '0 : col_reg + COL_W'(1);
        row_next = row_end ? (row_last ? '0 : row_reg + ROW_W'(1)) : row_reg;

        tag_next.row_end   = row_end;
        tag_next.last_row  = row_last;
        tag_next.row_index = mvm_pkg::ROW_INDEX_W'(row_reg);
    end

    // accumulate the product from the multiply stage
    assign acc_sum = acc_reg + mvm_pkg::DOT_W'(prod_reg);

    // vector memory
    mvm_ram #(
        .WIDTH(mvm_pkg::SAMPLE_W),
        .DEPTH(MAX_COLS)
    ) u_vec_ram (
        .clk  (clk),
        .we   (vec_write),
        .waddr(load_idx_reg),
        .wdata(sample_value),
        .re   (weight_read),
        .raddr(col_reg),
        .rdata(vec_rdata)
    );

    // config and sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= mvm_pkg::CFG_W'(1);
            cols_reg     <= mvm_pkg::CFG_W'(1);
            load_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mvm_pkg::REG_ROWS_IN_USE:
                begin
                    rows_reg <= cfg_rows_next;
                end
                mvm_pkg::REG_COLS_IN_USE:
                begin
                    cols_reg <= cfg_cols_next;
                end
                default:
                begin
                end
            endcase
            load_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (vec_write)
                load_idx_reg <= load_idx_next;
            if (weight_read)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // pipeline control and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            acc_reg <= '0;
            if (!result_stall)
                result_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s1_valid_reg <= weight_read;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
                acc_reg <= s2_tag_reg.row_end ? '0 : acc_sum;
            if (s2_valid_reg && s2_tag_reg.row_end)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (weight_read)
        begin
            s1_sample_reg <= sample_value;
            s1_tag_reg    <= tag_next;
        end
        if (!hold && s1_valid_reg)
        begin
            prod_reg   <= s1_sample_reg * $signed(vec_rdata);
            s2_tag_reg <= s1_tag_reg;
        end
        if (!hold && s2_valid_reg && s2_tag_reg.row_end)
        begin
            dot_reg       <= acc_sum;
            row_index_reg <= s2_tag_reg.row_index;
            last_row_reg  <= s2_tag_reg.last_row;
        end
    end

    assign result_valid = result_valid_reg;
    assign dot_value    = dot_reg;
    assign row_index    = row_index_reg;
    assign last_row     = last_row_reg;

    // checks
`include "matrix_vector_multiply_macros.svh"
    `MVM_ASSERT_IMPL(a_col_in_range, 1'b1, CNT_W'(col_reg) < CNT_W'(cols_reg))
    `MVM_ASSERT_IMPL(a_load_in_range, 1'b1, CNT_W'(load_idx_reg) < CNT_W'(cols_reg))
    `MVM_ASSERT_NEXT(a_row_end_clears_acc, !cfg_write_en && !hold && s2_valid_reg && s2_tag_reg.row_end, acc_reg == '0 && result_valid)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// testbench for matrix_vector_multiply: directed table, random size/item phases, tall matrix
// results checked vs in-bench dot product predictor or known sums; needs mvm_pkg and the RTL
module tb;

    localparam int MAX_COLS     = 4096;
    localparam int MAX_ROWS     = 4096;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TALL_WEIGHTS = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_STEPS      = 26;

    localparam logic ACT_VECTOR = mvm_pkg::ACT_VECTOR;
    localparam logic ACT_WEIGHT = mvm_pkg::ACT_WEIGHT;

    typedef enum logic [1:0] {STEP_ITEM, STEP_ITEM_KNOWN, STEP_WRITE} step_kind_t;

    typedef struct packed {
        logic [mvm_pkg::DOT_W-1:0]       dot;
        logic [mvm_pkg::ROW_INDEX_W-1:0] row;
        logic                            last;
    } row_result_t;

    typedef struct packed {
        step_kind_t                    kind;
        logic [mvm_pkg::CFG_IDX_W-1:0] reg_index;
        logic [mvm_pkg::CFG_W-1:0]     reg_value;
        logic                          act;
        logic [mvm_pkg::SAMPLE_W-1:0]  sample;
        row_result_t                   known;
    } directed_step_t;

    logic                                clk;
    logic                                rst_n        = 1'b0;
    logic                                cfg_write_en = 1'b0;
    logic [mvm_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [mvm_pkg::CFG_W-1:0]           cfg_data     = '0;
    logic                                sample_valid = 1'b0;
    logic                                sample_stall;
    logic                                action       = 1'b0;
    logic signed [mvm_pkg::SAMPLE_W-1:0] sample_value = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    logic signed [mvm_pkg::DOT_W-1:0]    dot_value;
    logic [mvm_pkg::ROW_INDEX_W-1:0]     row_index;
    logic                                last_row;

    // predictor state: vector copy, sequencing counters, running row sum, sizes
    logic signed [mvm_pkg::SAMPLE_W-1:0] vector_copy [MAX_COLS];
    int                                  load_pos    = 0;
    int                                  col_pos     = 0;
    int                                  row_pos     = 0;
    int                                  loaded_upto = 0;
    int                                  rows_now    = 1;
    int                                  cols_now    = 1;
    logic signed [mvm_pkg::DOT_W-1:0]    row_sum     = '0;

    row_result_t expected_rows [$];
    row_result_t want;
    int          mismatches    = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          writes_done   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    // directed table: extremes, mid-matrix vector reload, matrix wrap, zero sizes
    directed_step_t directed_steps [N_STEPS] = '{
        '{STEP_ITEM,       '0, '0, ACT_VECTOR, 16'h8000, '0},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'h8000, '{48'sd1073741824, 12'd0, 1'b1}},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'h7FFF, '{-48'sd1073709056, 12'd0, 1'b1}},
        '{STEP_ITEM,       '0, '0, ACT_VECTOR, 16'h7FFF, '0},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'h7FFF, '{48'sd1073676289, 12'd0, 1'b1}},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'h0000, '{48'sd0, 12'd0, 1'b1}},
        '{STEP_WRITE, mvm_pkg::REG_ROWS_IN_USE, 13'd3, ACT_VECTOR, '0, '0},
        '{STEP_WRITE, mvm_pkg::REG_COLS_IN_USE, 13'd2, ACT_VECTOR, '0, '0},
        '{STEP_ITEM,       '0, '0, ACT_VECTOR, 16'h0001, '0},
        '{STEP_ITEM,       '0, '0, ACT_VECTOR, 16'hFFFF, '0},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'h1000, '0},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'h8000, '{48'sd36864, 12'd0, 1'b0}},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'h5555, '0},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'hAAAA, '0},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'h0007, '0},
        '{STEP_ITEM,       '0, '0, ACT_VECTOR, 16'h1234, '0},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'hFFF9, '{48'sd14, 12'd2, 1'b1}},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'h8000, '0},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'h7FFF, '0},
        '{STEP_WRITE, mvm_pkg::REG_ROWS_IN_USE, 13'd0, ACT_VECTOR, '0, '0},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'h0001, '0},
        '{STEP_ITEM,       '0, '0, ACT_WEIGHT, 16'h0001, '0},
        '{STEP_WRITE, mvm_pkg::REG_COLS_IN_USE, 13'd0, ACT_VECTOR, '0, '0},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'h0002, '{48'sd9320, 12'd0, 1'b1}},
        '{STEP_ITEM,       '0, '0, ACT_VECTOR, 16'hFFFF, '0},
        '{STEP_ITEM_KNOWN, '0, '0, ACT_WEIGHT, 16'hFFFF, '{48'sd1, 12'd0, 1'b1}}
    };

    matrix_vector_multiply #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("[matrix_vector_multiply] ERROR");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // one accepted item through the predictor; a completed row gives a result
    task automatic predict_row_sum(input logic act,
                                   input logic signed [mvm_pkg::SAMPLE_W-1:0] val,
                                   output bit produced, output row_result_t res);
        logic signed [2*mvm_pkg::SAMPLE_W-1:0] prod;
        produced = 1'b0;
        res      = '0;
        if (act == ACT_VECTOR)
        begin
            vector_copy[load_pos] = val;
            load_pos++;
            if (load_pos > loaded_upto)
                loaded_upto = load_pos;
            if (load_pos >= cols_now)
                load_pos = 0;
        end
        else
        begin
            prod    = val * vector_copy[col_pos];
            row_sum = row_sum + prod;
            if (col_pos + 1 < cols_now)
                col_pos++;
            else
            begin
                produced = 1'b1;
                res.dot  = row_sum;
                res.row  = row_pos[mvm_pkg::ROW_INDEX_W-1:0];
                res.last = (row_pos + 1 >= rows_now);
                row_sum  = '0;
                col_pos  = 0;
                row_pos  = res.last ? 0 : row_pos + 1;
            end
        end
    endtask

    function automatic int clamp_size(input logic [mvm_pkg::CFG_W-1:0] v, input int top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return int'(v);
    endfunction

    function automatic logic [mvm_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return mvm_pkg::SAMPLE_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // mostly small sizes, sometimes zero or one
    function automatic logic [mvm_pkg::CFG_W-1:0] pick_size(input int top);
        case ($urandom_range(15))
            0: return '0;
            1: return mvm_pkg::CFG_W'(1);
            default: return mvm_pkg::CFG_W'($urandom_range(top, 2));
        endcase
    endfunction

    // size write once the block has drained
    task automatic program_size(input logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mvm_pkg::CFG_W-1:0] val);
        sample_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == mvm_pkg::REG_ROWS_IN_USE)
            rows_now = clamp_size(val, MAX_ROWS);
        else
            cols_now = clamp_size(val, MAX_COLS);
        load_pos = 0;
        col_pos  = 0;
        row_pos  = 0;
        row_sum  = '0;
        writes_done++;
    endtask

    // present one item, with an optional idle gap, and hold it until accepted
    task automatic send_item(input logic act, input logic [mvm_pkg::SAMPLE_W-1:0] val,
                             input bit use_known, input row_result_t known);
        bit          produced;
        row_result_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        sample_valid <= 1'b1;
        action       <= act;
        sample_value <= val;
        do
            @(posedge clk);
        while (sample_stall);
        items_sent++;
        predict_row_sum(act, val, produced, res);
        if (produced)
            expected_rows.push_back(use_known ? known : res);
    endtask

    // result side: random stall and in-order check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_rows.size() == 0)
                    log_mismatch($sformatf("unexpected result row %0d sum %0d",
                                           row_index, dot_value));
                else
                begin
                    want = expected_rows.pop_front();
                    if (dot_value !== want.dot)
                        log_mismatch($sformatf("row %0d sum %0d, want %0d",
                                               want.row, dot_value, $signed(want.dot)));
                    if (row_index !== want.row)
                        log_mismatch($sformatf("row index %0d, want %0d", row_index, want.row));
                    if (last_row !== want.last)
                        log_mismatch($sformatf("row %0d last flag %0b, want %0b",
                                               want.row, last_row, want.last));
                end
            end
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // stimulus
    initial
    begin
        int phase;
        int start;
        int count;
        int choice;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_STEPS; i++)
        begin
            if (directed_steps[i].kind == STEP_WRITE)
                program_size(directed_steps[i].reg_index, directed_steps[i].reg_value);
            else
                send_item(directed_steps[i].act, directed_steps[i].sample,
                          directed_steps[i].kind == STEP_ITEM_KNOWN, directed_steps[i].known);
        end

        // random phases: new sizes, usually a full vector, then mostly weights
        phase = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            choice = $urandom_range(2);
            if (choice != 1)
                program_size(mvm_pkg::REG_ROWS_IN_USE, pick_size(6));
            if (choice != 0)
                program_size(mvm_pkg::REG_COLS_IN_USE, pick_size(12));
            if ($urandom_range(4) != 0 || loaded_upto < cols_now)
                repeat (cols_now) send_item(ACT_VECTOR, pick_sample(), 1'b0, '0);
            count = $urandom_range(110, 40);
            repeat (count)
            begin
                if (loaded_upto >= cols_now && $urandom_range(7) != 0)
                    send_item(ACT_WEIGHT, pick_sample(), 1'b0, '0);
                else
                    send_item(ACT_VECTOR, pick_sample(), 1'b0, '0);
            end
            phase++;
        end

        // tall matrix: all-ones row write clamps to the maximum, one column
        send_idle_pct = 6;
        stall_pct     = 6;
        program_size(mvm_pkg::REG_ROWS_IN_USE, '1);
        program_size(mvm_pkg::REG_COLS_IN_USE, '0);
        send_item(ACT_VECTOR, pick_sample(), 1'b0, '0);
        repeat (TALL_WEIGHTS) send_item(ACT_WEIGHT, pick_sample(), 1'b0, '0);

        // drain
        sample_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d items sent, %0d row results checked, %0d size writes, %0d random phases",
                 items_sent, results_seen, writes_done, phase);
        $display("run: zero, small and clamped sizes under sender gaps and result back-pressure");
        if (mismatches == 0)
            $display("[matrix_vector_multiply] OK");
        else
            $display("[matrix_vector_multiply] ERROR");
        $finish;
    end

endmodule
